>>> hdl/jdp_pkg.sv
// Package for the JTAG-DP transfer engine.
// Holds the stream field layout, scan constants, phase and result codes and shared structs.
// Used by every module of the block; depends on nothing.
package jdp_pkg;

  // stream widths, fields packed from bit 0 and padded to whole bytes
  localparam int unsigned InTdataW  = 80;
  localparam int unsigned OutTdataW = 80;

  // JTAG-DP scan constants
  localparam logic [3:0]  IrDpacc     = 4'b1010;
  localparam logic [3:0]  IrApacc     = 4'b1011;
  localparam logic [2:0]  AckOk       = 3'b010;
  localparam logic [5:0]  IrLen       = 6'd4;
  localparam logic [5:0]  DrLen       = 6'd35;
  localparam logic [3:0]  RdbuffAddr  = 4'hc;
  localparam logic [3:0]  SelectAddr  = 4'h8;
  localparam logic [15:0] RetryLimitReset = 16'd500;

  typedef enum logic [0:0] {
    CFG_RETRY_LIMIT = 1'b0,
    CFG_AP_SELECT   = 1'b1
  } cfg_index_e;

  typedef enum logic [0:0] {
    KIND_REQUEST = 1'b0,
    KIND_CAPTURE = 1'b1
  } in_kind_e;

  typedef enum logic [1:0] {
    RK_IR_SCAN = 2'd0,
    RK_DR_SCAN = 2'd1,
    RK_DONE    = 2'd2
  } result_kind_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SEL_IR  = 3'd1,
    PH_SEL_WR  = 3'd2,
    PH_SEL_RB  = 3'd3,
    PH_ACC_IR  = 3'd4,
    PH_ACC_DR  = 3'd5,
    PH_POLL_IR = 3'd6,
    PH_POLL    = 3'd7
  } phase_e;

  typedef struct packed {
    in_kind_e    kind;
    logic        port_is_ap;
    logic        is_read;
    logic [7:0]  reg_address;
    logic [31:0] write_data;
    logic [34:0] scan_capture;
  } item_t;

  typedef struct packed {
    result_kind_e result_kind;
    logic [34:0]  scan_bits;
    logic [5:0]   scan_length;
    logic [31:0]  read_data;
    logic         transfer_ok;
  } result_t;

  // SELECT value for a request: AP number in 27:24, bank in 7:4 (AP) or 3:0 (DP)
  function automatic logic [31:0] wanted_select(input logic ap, input logic [7:0] bank_reg,
                                                input logic [3:0] ap_sel);
    logic [31:0] sel;
    sel = {4'h0, ap_sel, 24'h0};
    if (ap) begin
      sel[7:4] = bank_reg[7:4];
    end else begin
      sel[3:0] = bank_reg[7:4];
    end
    return sel;
  endfunction

  // DR scan word: bit 0 RnW, bits 2:1 A[3:2], bits 34:3 data
  function automatic logic [34:0] dr_word(input logic [31:0] data, input logic [3:0] addr,
                                          input logic rnw);
    return {data, addr[3:2], rnw};
  endfunction

endpackage

>>> hdl/jtag_dp_transfer_engine.sv
// Top level of the JTAG-DP transfer engine.
// Holds the configuration registers and joins input register, sequencer and result register.
// Depends on jdp_pkg, jdp_in_stage, jdp_seq and jdp_out_stage.

// Turns DP/AP register requests into IR (4-bit) and DR (35-bit) scan commands for an
// external TAP shifter; each scan's captured bits come back on the input stream as a
// capture item and advance the sequence, and a finished item reports read data and status.
// Every input item is registered on accept, stepped through the sequencer logic once the
// result register has room, and its result, if any, lands in the output register, so one
// item per cycle is taken as long as the result register can drain.
// Requests that arrive while a transfer is in flight, and captures while idle, give no result.
// Configuration writes are taken at any time and must only be issued while idle.
module jtag_dp_transfer_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // port_is_ap[0], is_read[1], reg_address[9:2], write_data[41:10], scan_capture[76:42]
  input  logic [jdp_pkg::InTdataW-1:0]  s_axis_tdata,
  // kind[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // scan_bits[34:0], scan_length[40:35], read_data[72:41], transfer_ok[73]
  output logic [jdp_pkg::OutTdataW-1:0] m_axis_tdata,
  // result_kind[1:0]
  output logic [1:0]                    m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [0:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import jdp_pkg::*;

  logic [15:0] retry_limit_q;
  logic [3:0]  ap_select_q;
  logic        in_valid, out_free, step, emit;
  item_t       item;
  result_t     result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RetryLimitReset;
      ap_select_q   <= 4'h0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_RETRY_LIMIT: retry_limit_q <= cfg_data_i;
        CFG_AP_SELECT:   ap_select_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // an item steps only when the result register has room
  assign step = in_valid && out_free;

  jdp_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .step_i        (step),
    .valid_o       (in_valid),
    .item_o        (item)
  );

  jdp_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (item),
    .retry_limit_i (retry_limit_q),
    .ap_select_i   (ap_select_q),
    .emit_o        (emit),
    .result_o      (result)
  );

  jdp_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (step && emit),
    .result_i      (result),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> hdl/jdp_in_stage.sv
// Input register of the JTAG-DP transfer engine.
// Unpacks the slave stream into an item and holds it until the sequencer steps.
// Depends on jdp_pkg.
module jdp_in_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [jdp_pkg::InTdataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  logic                          step_i,
  output logic                          valid_o,
  output jdp_pkg::item_t                item_o
);
  import jdp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  assign s_axis_tready = !valid_q || step_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d              = item_q;
    item_d.kind         = in_kind_e'(s_axis_tuser);
    item_d.port_is_ap   = s_axis_tdata[0];
    item_d.is_read      = s_axis_tdata[1];
    item_d.reg_address  = s_axis_tdata[9:2];
    item_d.write_data   = s_axis_tdata[41:10];
    item_d.scan_capture = s_axis_tdata[76:42];
  end

  always_comb begin
    if (take) begin
      valid_d = 1'b1;
    end else if (step_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hdl/jdp_seq.sv
// Transfer sequencer of the JTAG-DP transfer engine.
// Holds the phase, the IR and SELECT caches, the pending request and the poll counter,
// and works out one step per item. Depends on jdp_pkg.
module jdp_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  jdp_pkg::item_t   item_i,
  input  logic [15:0]      retry_limit_i,
  input  logic [3:0]       ap_select_i,
  output logic             emit_o,
  output jdp_pkg::result_t result_o
);
  import jdp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  cached_ir_q, cached_ir_d;
  logic        ir_known_q, ir_known_d;
  logic [31:0] cached_sel_q, cached_sel_d;
  logic        sel_known_q, sel_known_d;
  logic [15:0] retry_q, retry_d;

  logic        pend_ap_q, pend_read_q;
  logic [7:0]  pend_reg_q;
  logic [31:0] pend_data_q;

  logic        is_req, take_req;
  logic        eff_ap, eff_read;
  logic [7:0]  eff_reg;
  logic [31:0] eff_data;
  logic [31:0] want_sel;
  logic [3:0]  acc_ir;
  logic [15:0] retry_inc, limit;
  logic [2:0]  ack;

  logic        do_access, do_poll, do_selwr, do_rdbuff, do_ir, do_finish;
  logic [3:0]  ir_val;
  logic [31:0] fin_data;
  logic        fin_ok;

  assign is_req   = (item_i.kind == KIND_REQUEST);
  assign take_req = is_req && (phase_q == PH_IDLE);
  assign eff_ap   = take_req ? item_i.port_is_ap  : pend_ap_q;
  assign eff_read = take_req ? item_i.is_read     : pend_read_q;
  assign eff_reg  = take_req ? item_i.reg_address : pend_reg_q;
  assign eff_data = take_req ? item_i.write_data  : pend_data_q;
  assign want_sel = wanted_select(eff_ap, eff_reg, ap_select_i);
  assign acc_ir   = eff_ap ? IrApacc : IrDpacc;
  assign ack      = item_i.scan_capture[2:0];
  assign retry_inc = retry_q + 16'd1;
  assign limit    = (retry_limit_i == 16'd0) ? 16'd1 : retry_limit_i;

  // decode the step into one action
  always_comb begin
    phase_d      = phase_q;
    cached_sel_d = cached_sel_q;
    sel_known_d  = sel_known_q;
    retry_d      = retry_q;
    do_access    = 1'b0;
    do_poll      = 1'b0;
    do_selwr     = 1'b0;
    do_rdbuff    = 1'b0;
    do_ir        = 1'b0;
    do_finish    = 1'b0;
    ir_val       = IrDpacc;
    fin_data     = 32'h0;
    fin_ok       = 1'b0;
    if (is_req) begin
      if (take_req) begin
        if (sel_known_q && cached_sel_q == want_sel) begin
          do_access = 1'b1;
        end else if (!ir_known_q || cached_ir_q != IrDpacc) begin
          do_ir   = 1'b1;
          phase_d = PH_SEL_IR;
        end else begin
          do_selwr = 1'b1;
        end
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: ;
        PH_SEL_IR: do_selwr = 1'b1;
        PH_SEL_WR: begin
          phase_d   = PH_SEL_RB;
          do_rdbuff = 1'b1;
        end
        PH_SEL_RB: begin
          if (ack != AckOk) begin
            do_finish = 1'b1;
          end else begin
            cached_sel_d = want_sel;
            sel_known_d  = 1'b1;
            do_access    = 1'b1;
          end
        end
        PH_ACC_IR:  do_access = 1'b1;
        PH_ACC_DR:  do_poll   = 1'b1;
        PH_POLL_IR: do_poll   = 1'b1;
        PH_POLL: begin
          if (ack == AckOk) begin
            do_finish = 1'b1;
            fin_ok    = 1'b1;
            fin_data  = eff_read ? item_i.scan_capture[34:3] : 32'h0;
          end else begin
            retry_d = retry_inc;
            if (retry_inc >= limit) begin
              do_finish = 1'b1;
            end else begin
              do_rdbuff = 1'b1;
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end

    // access start: IR first when the cached IR differs
    if (do_access) begin
      if (!ir_known_q || cached_ir_q != acc_ir) begin
        do_ir   = 1'b1;
        ir_val  = acc_ir;
        phase_d = PH_ACC_IR;
      end else begin
        phase_d = PH_ACC_DR;
      end
    end
    // poll start: DPACC IR first when needed
    if (do_poll) begin
      if (!ir_known_q || cached_ir_q != IrDpacc) begin
        do_ir   = 1'b1;
        phase_d = PH_POLL_IR;
      end else begin
        retry_d   = 16'd0;
        phase_d   = PH_POLL;
        do_rdbuff = 1'b1;
      end
    end
    if (do_selwr) begin
      phase_d = PH_SEL_WR;
    end
    if (do_finish) begin
      phase_d = PH_IDLE;
    end
  end

  // build the result
  always_comb begin
    cached_ir_d = cached_ir_q;
    ir_known_d  = ir_known_q;
    emit_o      = 1'b1;
    result_o    = '{result_kind: RK_DR_SCAN, scan_bits: 35'h0, scan_length: DrLen,
                    read_data: 32'h0, transfer_ok: 1'b0};
    priority if (do_ir) begin
      cached_ir_d          = ir_val;
      ir_known_d           = 1'b1;
      result_o.result_kind = RK_IR_SCAN;
      result_o.scan_bits   = {31'h0, ir_val};
      result_o.scan_length = IrLen;
    end else if (do_finish) begin
      result_o.result_kind = RK_DONE;
      result_o.scan_length = 6'd0;
      result_o.read_data   = fin_data;
      result_o.transfer_ok = fin_ok;
    end else if (do_rdbuff) begin
      result_o.scan_bits = dr_word(32'h0, RdbuffAddr, 1'b1);
    end else if (do_selwr) begin
      result_o.scan_bits = dr_word(want_sel, SelectAddr, 1'b0);
    end else if (do_access) begin
      result_o.scan_bits = dr_word(eff_read ? 32'h0 : eff_data, eff_reg[3:0], eff_read);
    end else begin
      emit_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      cached_ir_q  <= 4'h0;
      ir_known_q   <= 1'b0;
      cached_sel_q <= 32'h0;
      sel_known_q  <= 1'b0;
      retry_q      <= 16'd0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      cached_ir_q  <= cached_ir_d;
      ir_known_q   <= ir_known_d;
      cached_sel_q <= cached_sel_d;
      sel_known_q  <= sel_known_d;
      retry_q      <= retry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && take_req) begin
      pend_ap_q   <= item_i.port_is_ap;
      pend_read_q <= item_i.is_read;
      pend_reg_q  <= item_i.reg_address;
      pend_data_q <= item_i.write_data;
    end
  end

endmodule

>>> hdl/jdp_out_stage.sv
// Result register of the JTAG-DP transfer engine.
// Packs one result onto the master stream and holds it until the transfer completes.
// Depends on jdp_pkg.
module jdp_out_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  jdp_pkg::result_t              result_i,
  output logic                          free_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [jdp_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic [1:0]                    m_axis_tuser
);
  import jdp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = res_q.result_kind;
  assign m_axis_tdata  = {6'h0, res_q.transfer_ok, res_q.read_data, res_q.scan_length,
                          res_q.scan_bits};

endmodule

>>> hdl/jdp_checker.sv
// Port-level checks for the JTAG-DP transfer engine.
// Watches the top level's ports only and is bound to it below; depends on jdp_pkg.
module jdp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [jdp_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic [1:0]                    m_axis_tuser
);
  import jdp_pkg::*;

  logic is_ir, is_dr, is_done;

  assign is_ir   = m_axis_tvalid && (m_axis_tuser == RK_IR_SCAN);
  assign is_dr   = m_axis_tvalid && (m_axis_tuser == RK_DR_SCAN);
  assign is_done = m_axis_tvalid && (m_axis_tuser == RK_DONE);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // IR scans carry DPACC or APACC with length 4
  a_ir_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_ir |-> m_axis_tdata[40:35] == IrLen && m_axis_tdata[34:4] == 31'h0 &&
      (m_axis_tdata[3:0] == IrDpacc || m_axis_tdata[3:0] == IrApacc) &&
      m_axis_tdata[73:41] == 33'h0)
    else $error("bad IR scan command");

  // DR scans are 35 bits and carry no status
  a_dr_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_dr |-> m_axis_tdata[40:35] == DrLen && m_axis_tdata[73:41] == 33'h0)
    else $error("bad DR scan command");

  // finished results shift nothing, failures return no data
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_done |-> m_axis_tdata[40:0] == 41'h0 &&
      (m_axis_tdata[73] || m_axis_tdata[72:41] == 32'h0))
    else $error("bad finished result");

endmodule

bind jtag_dp_transfer_engine jdp_checker u_jdp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
